// ----- hdl/phong_fragment_lighting_top_macros.svh -----
// Assertion macros for the Phong fragment lighting block.
// Included by the modules that check their own pipeline invariants.
`ifndef PHONG_FRAGMENT_LIGHTING_TOP_MACROS_SVH
`define PHONG_FRAGMENT_LIGHTING_TOP_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define PFL_ASSERT_NOW(lbl, ck, rn, trig, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define PFL_ASSERT_NEXT(lbl, ck, rn, trig, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (cond)) else $error(msg);

`endif

// ----- hdl/pfl_pkg.sv -----
// Shared types, constants and helpers for the Phong fragment lighting block.
// No dependencies.
`default_nettype none
package pfl_pkg;

    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_DATA_W    = 64;
    localparam int SHININESS_DEF = 32;

    localparam logic [14:0] ONE_Q14     = 15'd16384;
    localparam logic [14:0] AMBIENT_Q14 = 15'd1638;
    localparam logic [14:0] F_MAX       = 15'd26214;

    typedef enum logic [2:0] {
        REG_LIGHT_RGB,
        REG_SURFACE_RGB,
        REG_LAMP_X,
        REG_LAMP_Y,
        REG_LAMP_Z,
        REG_EYE_X,
        REG_EYE_Y,
        REG_EYE_Z
    } pfl_reg_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] frag_x;
        logic signed [15:0] frag_y;
        logic signed [15:0] frag_z;
    } pfl_in_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pfl_out_t;

    // Clamp a dot product in Q2.28 to a Q1.14 scalar in [0, 1].
    function automatic logic [14:0] clamp_dot(input logic signed [37:0] d);
        logic [23:0] q;
        q = 24'(d >>> 14);
        if (d <= 0)
            return '0;
        else if (q > 24'(ONE_Q14))
            return ONE_Q14;
        else
            return q[14:0];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/phong_fragment_lighting_top.sv -----
// Phong fragment lighting, one point light, fully pipelined top level.
// Depends on pfl_pkg and phong_fragment_lighting_top_macros.svh.
//
//  Channel   | Handshake              | Payload     | Beat
//  ----------+------------------------+-------------+------------------------------
//  fragment  | frag_valid/frag_ready  | frag_data   | normal and position, in
//  pixel     | pix_valid/pix_ready    | pix_data    | shaded RGB, out
//  config    | psel/penable/pwrite    | paddr/pwdata| one register write or read
//
// One fragment enters per cycle while no pixel beat is held. The depth is set
// by the bit-serial square roots (31 stages), the restoring dividers
// (15 stages) and one multiplier stage per power step.
// Reset clears the valid pipe and the configuration registers.
// A held pixel beat freezes the whole pipe; no beat is lost or repeated.
`default_nettype none
`include "phong_fragment_lighting_top_macros.svh"
module phong_fragment_lighting_top
    import pfl_pkg::*;
#(
    parameter int SHININESS = SHININESS_DEF
)(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    frag_valid,
    output logic                   frag_ready,
    input  wire pfl_in_t           frag_data,
    output logic                   pix_valid,
    input  wire                    pix_ready,
    output pfl_out_t               pix_data,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [CFG_ADDR_W-1:0]   paddr,
    input  wire [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 15;
    localparam int ST_UNIT    = 3 + SQRT_STEPS + DIV_STEPS;   // unit vectors
    localparam int ST_PW0     = ST_UNIT + 7;                  // power seed
    localparam int ST_F       = ST_PW0 + SHININESS + 1;       // intensity
    localparam int LAT        = ST_F + 3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [47:0] light_rgb_reg;
    logic        [47:0] surface_rgb_reg;
    logic signed [15:0] lamp_reg [0:2];
    logic signed [15:0] eye_reg  [0:2];
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_rgb_reg   <= '0;
            surface_rgb_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                lamp_reg[i] <= '0;
                eye_reg[i]  <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (pfl_reg_t'(paddr[5:3]))
                REG_LIGHT_RGB:   light_rgb_reg   <= pwdata[47:0];
                REG_SURFACE_RGB: surface_rgb_reg <= pwdata[47:0];
                REG_LAMP_X:      lamp_reg[0]     <= pwdata[15:0];
                REG_LAMP_Y:      lamp_reg[1]     <= pwdata[15:0];
                REG_LAMP_Z:      lamp_reg[2]     <= pwdata[15:0];
                REG_EYE_X:       eye_reg[0]      <= pwdata[15:0];
                REG_EYE_Y:       eye_reg[1]      <= pwdata[15:0];
                REG_EYE_Z:       eye_reg[2]      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (pfl_reg_t'(paddr[5:3]))
            REG_LIGHT_RGB:   prdata = {16'd0, light_rgb_reg};
            REG_SURFACE_RGB: prdata = {16'd0, surface_rgb_reg};
            REG_LAMP_X:      prdata = {48'd0, lamp_reg[0]};
            REG_LAMP_Y:      prdata = {48'd0, lamp_reg[1]};
            REG_LAMP_Z:      prdata = {48'd0, lamp_reg[2]};
            REG_EYE_X:       prdata = {48'd0, eye_reg[0]};
            REG_EYE_Y:       prdata = {48'd0, eye_reg[1]};
            REG_EYE_Z:       prdata = {48'd0, eye_reg[2]};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: one enable for every stage, valid bits alongside
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic           adv;

    assign adv        = !vld_reg[LAT-1] || pix_ready;
    assign frag_ready = adv;
    assign pix_valid  = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], frag_valid};
    end

    // ------------------------------------------------------------------
    // Stage 1: raw vectors. Vector 0 is the normal, 1 the light direction,
    // 2 the view direction.
    // ------------------------------------------------------------------
    logic signed [15:0] in_nrm [0:2];
    logic signed [15:0] in_pos [0:2];
    logic signed [16:0] s1_v_reg [0:2][0:2];

    assign in_nrm[0] = frag_data.normal_x;
    assign in_nrm[1] = frag_data.normal_y;
    assign in_nrm[2] = frag_data.normal_z;
    assign in_pos[0] = frag_data.frag_x;
    assign in_pos[1] = frag_data.frag_y;
    assign in_pos[2] = frag_data.frag_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s1_v_reg[0][c] <= 17'(in_nrm[c]);
                s1_v_reg[1][c] <= 17'(lamp_reg[c]) - 17'(in_pos[c]);
                s1_v_reg[2][c] <= 17'(eye_reg[c]) - 17'(in_pos[c]);
            end
        end
    end

    // Stage 2: magnitudes and squares
    logic [15:0] s2_mag_reg [0:2][0:2];
    logic        s2_neg_reg [0:2][0:2];
    logic [31:0] s2_sq_reg  [0:2][0:2];
    logic [15:0] s2_mag_next [0:2][0:2];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            for (int c = 0; c < 3; c++)
                s2_mag_next[j][c] = s1_v_reg[j][c][16] ? 16'(-s1_v_reg[j][c])
                                                       : 16'(s1_v_reg[j][c]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
                for (int c = 0; c < 3; c++)
                begin
                    s2_mag_reg[j][c] <= s2_mag_next[j][c];
                    s2_neg_reg[j][c] <= s1_v_reg[j][c][16];
                    s2_sq_reg[j][c]  <= 32'(s2_mag_next[j][c]) * 32'(s2_mag_next[j][c]);
                end
        end
    end

    // ------------------------------------------------------------------
    // Square roots: index 0 holds the radicand s * 2^28, then one result
    // bit per stage.
    // ------------------------------------------------------------------
    logic [61:0] sq_x_reg    [0:SQRT_STEPS][0:2];
    logic [61:0] sq_r_reg    [0:SQRT_STEPS][0:2];
    logic [15:0] sq_mag_reg  [0:SQRT_STEPS][0:2][0:2];
    logic        sq_neg_reg  [0:SQRT_STEPS][0:2][0:2];
    logic        sq_zero_reg [0:SQRT_STEPS][0:2];
    logic [33:0] s3_sum_next [0:2];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            s3_sum_next[j] = 34'(s2_sq_reg[j][0]) + 34'(s2_sq_reg[j][1])
                           + 34'(s2_sq_reg[j][2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sq_x_reg[0][j]    <= {s3_sum_next[j], 28'd0};
                sq_r_reg[0][j]    <= '0;
                sq_zero_reg[0][j] <= (s3_sum_next[j] == '0);
                sq_mag_reg[0][j]  <= s2_mag_reg[j];
                sq_neg_reg[0][j]  <= s2_neg_reg[j];
            end
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - k));
        logic [61:0] trial [0:2];
        logic        take  [0:2];

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                trial[j] = sq_r_reg[k][j] + BIT;
                take[j]  = sq_x_reg[k][j] >= trial[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    sq_x_reg[k+1][j]    <= take[j] ? sq_x_reg[k][j] - trial[j]
                                                   : sq_x_reg[k][j];
                    sq_r_reg[k+1][j]    <= take[j] ? (sq_r_reg[k][j] >> 1) + BIT
                                                   : sq_r_reg[k][j] >> 1;
                    sq_zero_reg[k+1][j] <= sq_zero_reg[k][j];
                    sq_mag_reg[k+1][j]  <= sq_mag_reg[k][j];
                    sq_neg_reg[k+1][j]  <= sq_neg_reg[k][j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring dividers: |v_i| * 2^28 / Lq, one quotient bit per stage.
    // The quotient never exceeds 2^14 because Lq >= |v_i| * 2^14.
    // ------------------------------------------------------------------
    logic [45:0] dv_rem_reg  [0:DIV_STEPS-1][0:2][0:2];
    logic [14:0] dv_q_reg    [0:DIV_STEPS-1][0:2][0:2];
    logic [30:0] dv_lq_reg   [0:DIV_STEPS-1][0:2];
    logic        dv_neg_reg  [0:DIV_STEPS-1][0:2][0:2];
    logic        dv_zero_reg [0:DIV_STEPS-1][0:2];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        logic [45:0] rem_in  [0:2][0:2];
        logic [14:0] q_in    [0:2][0:2];
        logic [30:0] lq_in   [0:2];
        logic        neg_in  [0:2][0:2];
        logic        zero_in [0:2];
        logic [45:0] dsr     [0:2];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lq_in[j]   = sq_r_reg[SQRT_STEPS][j][30:0];
                    zero_in[j] = sq_zero_reg[SQRT_STEPS][j];
                    for (int c = 0; c < 3; c++)
                    begin
                        rem_in[j][c] = {2'b00, sq_mag_reg[SQRT_STEPS][j][c], 28'd0};
                        q_in[j][c]   = '0;
                        neg_in[j][c] = sq_neg_reg[SQRT_STEPS][j][c];
                    end
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lq_in[j]   = dv_lq_reg[k-1][j];
                    zero_in[j] = dv_zero_reg[k-1][j];
                    for (int c = 0; c < 3; c++)
                    begin
                        rem_in[j][c] = dv_rem_reg[k-1][j][c];
                        q_in[j][c]   = dv_q_reg[k-1][j][c];
                        neg_in[j][c] = dv_neg_reg[k-1][j][c];
                    end
                end
            end
        end

        always_comb
        begin
            for (int j = 0; j < 3; j++)
                dsr[j] = {15'd0, lq_in[j]} << SH;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    dv_lq_reg[k][j]   <= lq_in[j];
                    dv_zero_reg[k][j] <= zero_in[j];
                    for (int c = 0; c < 3; c++)
                    begin
                        dv_neg_reg[k][j][c] <= neg_in[j][c];
                        if (rem_in[j][c] >= dsr[j])
                        begin
                            dv_rem_reg[k][j][c] <= rem_in[j][c] - dsr[j];
                            dv_q_reg[k][j][c]   <= q_in[j][c] | (15'd1 << SH);
                        end
                        else
                        begin
                            dv_rem_reg[k][j][c] <= rem_in[j][c];
                            dv_q_reg[k][j][c]   <= q_in[j][c];
                        end
                    end
                end
            end
        end
    end

    // Unit vectors in Q1.14; a zero-length vector gives zero
    logic signed [15:0] un_reg [0:2][0:2];
    logic        [14:0] un_mag_next [0:2][0:2];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            for (int c = 0; c < 3; c++)
            begin
                if (dv_zero_reg[DIV_STEPS-1][j])
                    un_mag_next[j][c] = '0;
                else if (dv_q_reg[DIV_STEPS-1][j][c] > ONE_Q14)
                    un_mag_next[j][c] = ONE_Q14;
                else
                    un_mag_next[j][c] = dv_q_reg[DIV_STEPS-1][j][c];
            end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
                for (int c = 0; c < 3; c++)
                    un_reg[j][c] <= dv_neg_reg[DIV_STEPS-1][j][c]
                                  ? -16'(un_mag_next[j][c]) : 16'(un_mag_next[j][c]);
        end
    end

    // ------------------------------------------------------------------
    // Dot products and reflection
    // ------------------------------------------------------------------
    logic signed [31:0] pa_prod_reg [0:2];
    logic signed [15:0] pa_vec_reg  [0:2][0:2];
    logic signed [33:0] pb_nl_reg;
    logic signed [15:0] pb_vec_reg  [0:2][0:2];
    logic signed [50:0] pc_t_reg    [0:2];
    logic        [14:0] pc_diff_reg;
    logic signed [15:0] pc_l_reg    [0:2];
    logic signed [15:0] pc_v_reg    [0:2];
    logic signed [19:0] pd_r_reg    [0:2];
    logic        [14:0] pd_diff_reg;
    logic signed [15:0] pd_v_reg    [0:2];
    logic signed [35:0] pe_prod_reg [0:2];
    logic        [14:0] pe_diff_reg;
    logic signed [37:0] pf_vr_reg;
    logic        [14:0] pf_diff_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // N.L products
            for (int c = 0; c < 3; c++)
                pa_prod_reg[c] <= 32'(un_reg[0][c]) * 32'(un_reg[1][c]);
            pa_vec_reg <= un_reg;

            pb_nl_reg  <= 34'(pa_prod_reg[0]) + 34'(pa_prod_reg[1])
                        + 34'(pa_prod_reg[2]);
            pb_vec_reg <= pa_vec_reg;

            // 2 (N.L) N_i, still scaled by 2^28
            for (int c = 0; c < 3; c++)
            begin
                pc_t_reg[c] <= (51'(pb_nl_reg) * 51'(pb_vec_reg[0][c])) <<< 1;
                pc_l_reg[c] <= pb_vec_reg[1][c];
                pc_v_reg[c] <= pb_vec_reg[2][c];
            end
            pc_diff_reg <= clamp_dot(38'(pb_nl_reg));

            // R = floor(2 (N.L) N / 2^28) - L
            for (int c = 0; c < 3; c++)
            begin
                pd_r_reg[c] <= 20'(23'(pc_t_reg[c] >>> 28) - 23'(pc_l_reg[c]));
                pd_v_reg[c] <= pc_v_reg[c];
            end
            pd_diff_reg <= pc_diff_reg;

            for (int c = 0; c < 3; c++)
                pe_prod_reg[c] <= 36'(pd_v_reg[c]) * 36'(pd_r_reg[c]);
            pe_diff_reg <= pd_diff_reg;

            pf_vr_reg   <= 38'(pe_prod_reg[0]) + 38'(pe_prod_reg[1])
                         + 38'(pe_prod_reg[2]);
            pf_diff_reg <= pe_diff_reg;
        end
    end

    // ------------------------------------------------------------------
    // Specular power: one multiply per stage, truncating each time
    // ------------------------------------------------------------------
    logic [14:0] pw_p_reg    [0:SHININESS];
    logic [14:0] pw_sp_reg   [0:SHININESS];
    logic [14:0] pw_diff_reg [0:SHININESS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pw_p_reg[0]    <= ONE_Q14;
            pw_sp_reg[0]   <= clamp_dot(pf_vr_reg);
            pw_diff_reg[0] <= pf_diff_reg;
        end
    end

    for (genvar k = 0; k < SHININESS; k++)
    begin : g_pow
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pw_p_reg[k+1]    <= 15'((30'(pw_p_reg[k]) * 30'(pw_sp_reg[k])) >> 14);
                pw_sp_reg[k+1]   <= pw_sp_reg[k];
                pw_diff_reg[k+1] <= pw_diff_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Intensity and colour
    // ------------------------------------------------------------------
    logic [14:0] f_reg;
    logic [16:0] c1_t_reg [0:2];
    logic [20:0] c2_o_next [0:2];
    logic [15:0] out_reg  [0:2];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            c2_o_next[c] = 21'((33'(c1_t_reg[c]) * 33'(surface_rgb_reg[16*c +: 16])) >> 12);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg <= AMBIENT_Q14 + pw_diff_reg[SHININESS] + (pw_p_reg[SHININESS] >> 1);
            for (int c = 0; c < 3; c++)
            begin
                c1_t_reg[c] <= 17'((31'(light_rgb_reg[16*c +: 16]) * 31'(f_reg)) >> 14);
                // saturate the channel at full scale
                out_reg[c]  <= (c2_o_next[c] > 21'h00FFFF) ? 16'hFFFF : c2_o_next[c][15:0];
            end
        end
    end

    assign pix_data.red   = out_reg[0];
    assign pix_data.green = out_reg[1];
    assign pix_data.blue  = out_reg[2];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PFL_ASSERT_NEXT(a_last_stage_fills, clk, rst_n, adv && vld_reg[LAT-2], pix_valid, "beat lost before output register")
    `PFL_ASSERT_NOW(a_power_bounded, clk, rst_n, vld_reg[ST_PW0+SHININESS], pw_p_reg[SHININESS] <= ONE_Q14, "specular power above one")
    `PFL_ASSERT_NOW(a_intensity_range, clk, rst_n, vld_reg[ST_F], (f_reg >= AMBIENT_Q14) && (f_reg <= F_MAX), "intensity out of range")

endmodule
`default_nettype wire
